### design/ppt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the permutation prefix trie.
// Used by every module of the block; depends on nothing.
package ppt_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int MAX_LEN_DEF    = 10;

  localparam int KEY_W       = 4;
  localparam int ELEM_W      = 4;
  localparam int FIELD_ELEMS = 10;
  localparam int PERM_W      = 40;
  localparam int OP_W        = 2;
  localparam int DEPTH_W     = 4;
  localparam int OUT_TDATA_W = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [KEY_W-1:0] KEY_LENGTH_RESET = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_NEW,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic               status;
    logic [DEPTH_W-1:0] match_depth;
  } result_t;

endpackage

### design/permutation_prefix_trie.sv
`timescale 1ns / 1ps
// Top level of the permutation prefix trie: front, queue and back part.
// Depends on ppt_pkg, ppt_front, ppt_queue and ppt_back.
//
// Usage:
//   in_*  : one transaction per operation. in_tuser carries the operation
//           (clear, insert inverse, query), in_tdata the ten 4-bit elements.
//   out_* : exactly one result per operation, in order: match_depth and status.
//   cfg_* : writes key_length; always ready. Write only while the block is idle.
// Flow:
//   The front classifies an operation in the accept cycle and queues it (two
//   entries). The back walker handles one operation at a time and does one
//   node-store access per trie level. A clear, an unknown operation or a zero
//   key_length goes straight to the result; an insert or query walks up to
//   key_length levels. The walker takes no new operation until its result is
//   in the output register, so throughput is set by the walker.
// Reset: key_length returns to 10 and the trie holds only an empty root; the
//   node store itself needs no clearing pass.
// Stall: a result waits in the output register while out_tready is low; the
//   queue keeps accepting until it fills, then in_tready drops.
module permutation_prefix_trie #(
  parameter int NODE_COUNT = ppt_pkg::NODE_COUNT_DEF,
  parameter int MAX_LEN    = ppt_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppt_pkg::KEY_W-1:0]           cfg_data,   // key_length
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ppt_pkg::OP_W-1:0]            in_tuser,   // operation
  input  logic [ppt_pkg::PERM_W-1:0]          in_tdata,   // permutation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ppt_pkg::OUT_TDATA_W-1:0]     out_tdata   // match_depth, status, zero pad
);

  localparam int DW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int QW = ppt_pkg::OP_W + LW + MAX_LEN * DW;
  localparam int RW = ppt_pkg::DEPTH_W + 1;

  ppt_pkg::op_t               f_op;
  logic [LW-1:0]              f_len;
  logic [MAX_LEN-1:0][DW-1:0] f_digits;
  logic                       push_valid;
  logic                       push_ready;
  logic [QW-1:0]              pop_data;
  logic                       pop_valid;
  logic                       pop_ready;
  ppt_pkg::op_t               b_op;
  logic [LW-1:0]              b_len;
  logic [MAX_LEN-1:0][DW-1:0] b_digits;
  ppt_pkg::result_t           result;

  ppt_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .entry_op     (f_op),
    .entry_len    (f_len),
    .entry_digits (f_digits)
  );

  ppt_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({f_op, f_len, f_digits}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign b_op     = ppt_pkg::op_t'(pop_data[QW-1 -: ppt_pkg::OP_W]);
  assign b_len    = pop_data[MAX_LEN*DW +: LW];
  assign b_digits = pop_data[MAX_LEN*DW-1:0];

  ppt_back #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_LEN    (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_op       (b_op),
    .q_len      (b_len),
    .q_digits   (b_digits),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (result)
  );

  assign out_tdata = {{(ppt_pkg::OUT_TDATA_W - RW){1'b0}}, result.status, result.match_depth};

endmodule

### design/ppt_front.sv
`timescale 1ns / 1ps
// Front part: holds key_length, classifies each transaction and forms its digit key.
// Depends on ppt_pkg.
module ppt_front #(
  parameter int MAX_LEN = ppt_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppt_pkg::KEY_W-1:0]         cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ppt_pkg::OP_W-1:0]          in_tuser,
  input  logic [ppt_pkg::PERM_W-1:0]        in_tdata,
  output logic                              push_valid,
  input  logic                              push_ready,
  output ppt_pkg::op_t                      entry_op,
  output logic [$clog2(MAX_LEN+1)-1:0]      entry_len,
  output logic [MAX_LEN-1:0][$clog2(MAX_LEN)-1:0] entry_digits
);

  localparam int DW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int EW = ppt_pkg::ELEM_W;

  logic [ppt_pkg::KEY_W-1:0] key_length_r;
  logic [ppt_pkg::KEY_W-1:0] key_length_nxt;
  logic [MAX_LEN-1:0][EW-1:0] elem;
  logic [MAX_LEN-1:0][DW-1:0] inv;
  logic [MAX_LEN-1:0][DW-1:0] qdig;
  logic [LW-1:0]              act_len;
  logic [LW-1:0]              qlen;

  assign cfg_ready  = 1'b1;
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    key_length_nxt = key_length_r;
    if (cfg_valid) begin
      key_length_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= ppt_pkg::KEY_LENGTH_RESET;
    end else begin
      key_length_r <= key_length_nxt;
    end
  end

  // Elements past the 40-bit field read as zero
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_elem
    if (g < ppt_pkg::FIELD_ELEMS) begin : g_in
      assign elem[g] = in_tdata[EW*g +: EW];
    end else begin : g_zero
      assign elem[g] = '0;
    end
    assign qdig[g] = DW'(elem[g]);
  end

  always_comb begin
    if (int'(key_length_r) > MAX_LEN) begin
      act_len = LW'(MAX_LEN);
    end else begin
      act_len = LW'(key_length_r);
    end
  end

  // Inverse: slot elem[j] gets j, later j wins, out-of-range values dropped
  always_comb begin
    for (int s = 0; s < MAX_LEN; s++) begin
      inv[s] = '0;
      for (int j = 0; j < MAX_LEN; j++) begin
        if ((j < int'(act_len)) && (int'(elem[j]) == s)) begin
          inv[s] = DW'(j);
        end
      end
    end
  end

  // Query walk ends at the first digit that has no child slot
  always_comb begin
    qlen = act_len;
    for (int j = MAX_LEN - 1; j >= 0; j--) begin
      if ((j < int'(act_len)) && (int'(elem[j]) >= MAX_LEN)) begin
        qlen = LW'(j);
      end
    end
  end

  always_comb begin
    entry_len    = act_len;
    entry_digits = inv;
    case (in_tuser)
      ppt_pkg::OP_CLEAR: begin
        entry_op = ppt_pkg::OP_CLEAR;
      end
      ppt_pkg::OP_INSERT: begin
        entry_op = ppt_pkg::OP_INSERT;
      end
      ppt_pkg::OP_QUERY: begin
        entry_op     = ppt_pkg::OP_QUERY;
        entry_len    = qlen;
        entry_digits = qdig;
      end
      default: begin
        entry_op = ppt_pkg::OP_NONE;
      end
    endcase
  end

endmodule

### design/ppt_queue.sv
`timescale 1ns / 1ps
// Short FIFO between the front and back parts of the prefix trie.
// Depends on ppt_pkg for its depth.
module ppt_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int QD = ppt_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  logic [W-1:0]  slot_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(QD));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/ppt_back.sv
`timescale 1ns / 1ps
// Back part: walks the node store one level per cycle, allocates nodes on insert,
// and holds the result register. Depends on ppt_pkg.
module ppt_back #(
  parameter int NODE_COUNT = ppt_pkg::NODE_COUNT_DEF,
  parameter int MAX_LEN    = ppt_pkg::MAX_LEN_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_valid,
  output logic                                    q_ready,
  input  ppt_pkg::op_t                            q_op,
  input  logic [$clog2(MAX_LEN+1)-1:0]            q_len,
  input  logic [MAX_LEN-1:0][$clog2(MAX_LEN)-1:0] q_digits,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output ppt_pkg::result_t                        out_result
);

  localparam int IDXW    = $clog2(NODE_COUNT);
  localparam int DW      = $clog2(MAX_LEN);
  localparam int LW      = $clog2(MAX_LEN + 1);
  localparam int DEPTH_W = ppt_pkg::DEPTH_W;

  typedef logic [MAX_LEN-1:0][IDXW-1:0] row_t;

  // Node store: one row of child indices per node, index 0 means no child
  row_t mem [NODE_COUNT];
  row_t rdata_r;

  ppt_pkg::back_state_t state_r, state_nxt;
  ppt_pkg::op_t         op_r, op_nxt;
  logic [LW-1:0]              len_r, len_nxt;
  logic [MAX_LEN-1:0][DW-1:0] digits_r, digits_nxt;
  logic [IDXW-1:0]            node_r, node_nxt;
  logic [LW-1:0]              level_r, level_nxt;
  logic                       status_r, status_nxt;
  logic [IDXW-1:0]            nodes_used_r, nodes_used_nxt;
  logic                       root_valid_r, root_valid_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ppt_pkg::result_t           out_result_r, out_result_nxt;

  row_t            row;
  row_t            wdata;
  logic            we;
  logic [IDXW-1:0] waddr;
  logic [IDXW-1:0] raddr;
  logic [DW-1:0]   cur_digit;
  logic [IDXW-1:0] child;
  logic            child_hit;
  logic            full;
  logic [IDXW-1:0] alloc;
  logic [LW-1:0]   level_inc;
  logic            last;
  logic            out_free;

  assign row        = ((node_r == '0) && !root_valid_r) ? '0 : rdata_r;
  assign cur_digit  = digits_r[level_r[DW-1:0]];
  assign child      = row[cur_digit];
  assign child_hit  = (child != '0);
  assign full       = (nodes_used_r == IDXW'(NODE_COUNT - 1));
  assign alloc      = nodes_used_r + IDXW'(1);
  assign level_inc  = level_r + LW'(1);
  assign last       = (level_inc == len_r);
  assign out_free   = !out_valid_r || out_tready;
  assign q_ready    = (state_r == ppt_pkg::BK_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_result = out_result_r;

  // Read the child's row while still in the walk so the next level is ready
  assign raddr = (state_r == ppt_pkg::BK_LOOK) ? child : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppt_pkg::BK_IDLE: begin
        if (q_valid) begin
          if ((q_op == ppt_pkg::OP_INSERT || q_op == ppt_pkg::OP_QUERY) && (q_len != '0)) begin
            state_nxt = ppt_pkg::BK_LOOK;
          end else begin
            state_nxt = ppt_pkg::BK_DONE;
          end
        end
      end
      ppt_pkg::BK_LOOK: begin
        if (child_hit) begin
          state_nxt = last ? ppt_pkg::BK_DONE : ppt_pkg::BK_LOOK;
        end else if (op_r == ppt_pkg::OP_INSERT && !full) begin
          state_nxt = ppt_pkg::BK_NEW;
        end else begin
          state_nxt = ppt_pkg::BK_DONE;
        end
      end
      ppt_pkg::BK_NEW: begin
        if ((level_r == len_r) || full) begin
          state_nxt = ppt_pkg::BK_DONE;
        end
      end
      ppt_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = ppt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = ppt_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    len_nxt        = len_r;
    digits_nxt     = digits_r;
    node_nxt       = node_r;
    level_nxt      = level_r;
    status_nxt     = status_r;
    nodes_used_nxt = nodes_used_r;
    root_valid_nxt = root_valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_result_nxt = out_result_r;
    we             = 1'b0;
    waddr          = node_r;
    wdata          = row;
    case (state_r)
      ppt_pkg::BK_IDLE: begin
        if (q_valid) begin
          op_nxt     = q_op;
          len_nxt    = q_len;
          digits_nxt = q_digits;
          node_nxt   = '0;
          level_nxt  = '0;
          status_nxt = 1'b0;
          if (q_op == ppt_pkg::OP_CLEAR) begin
            nodes_used_nxt = '0;
            root_valid_nxt = 1'b0;
          end
        end
      end
      ppt_pkg::BK_LOOK: begin
        if (child_hit) begin
          node_nxt  = child;
          level_nxt = level_inc;
        end else if (op_r == ppt_pkg::OP_INSERT) begin
          if (full) begin
            status_nxt = 1'b1;
          end else begin
            // Link a fresh node into the existing row
            we               = 1'b1;
            wdata[cur_digit] = alloc;
            nodes_used_nxt   = alloc;
            node_nxt         = alloc;
            level_nxt        = level_inc;
            if (node_r == '0) begin
              root_valid_nxt = 1'b1;
            end
          end
        end
      end
      ppt_pkg::BK_NEW: begin
        // Current node is freshly allocated: its row is written whole, which clears it
        we    = 1'b1;
        wdata = '0;
        if (level_r != len_r) begin
          if (full) begin
            status_nxt = 1'b1;
          end else begin
            wdata[cur_digit] = alloc;
            nodes_used_nxt   = alloc;
            node_nxt         = alloc;
            level_nxt        = level_inc;
          end
        end
      end
      ppt_pkg::BK_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_result_nxt.status  = status_r;
          out_result_nxt.match_depth =
            (op_r == ppt_pkg::OP_QUERY) ? DEPTH_W'(level_r) : '0;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppt_pkg::BK_IDLE;
      nodes_used_r <= '0;
      root_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      root_valid_r <= root_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    len_r        <= len_nxt;
    digits_r     <= digits_nxt;
    node_r       <= node_nxt;
    level_r      <= level_nxt;
    status_r     <= status_nxt;
    out_result_r <= out_result_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

`ifndef SYNTHESIS
  a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (op_r == ppt_pkg::OP_INSERT))
    else $error("node store written outside an insert");

  a_new_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppt_pkg::BK_NEW) |-> (node_r != '0))
    else $error("fresh node walk landed on the root");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppt_pkg::BK_DONE && op_r == ppt_pkg::OP_QUERY) |-> (level_r <= len_r))
    else $error("query depth beyond key length");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready && q_op == ppt_pkg::OP_CLEAR) |=>
      (nodes_used_r == '0 && !root_valid_r))
    else $error("clear left nodes allocated");
`endif

endmodule

### tb/sv/ppt_trie_checker.sv
`timescale 1ns / 1ps
// Result checker for the permutation prefix trie: tracks key_length writes, predicts
// each operation's match_depth and status, and compares results in order.
// Depends on ppt_pkg.
module ppt_trie_checker
  import ppt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [KEY_W-1:0]       cfg_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OP_W-1:0]        in_tuser,
  input  logic [PERM_W-1:0]      in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     answers_due
);

  localparam int NODES  = NODE_COUNT_DEF;
  localparam int DIGITS = MAX_LEN_DEF;
  localparam int NODE_W = $clog2(NODES);
  localparam int RES_W  = $bits(result_t);

  logic [NODE_W-1:0] child_of [NODES*DIGITS];
  int                nodes_used;
  logic [KEY_W-1:0]  key_length;
  result_t           trie_answers_q [$];

  function automatic int active_len();
    return (key_length > DIGITS) ? DIGITS : int'(key_length);
  endfunction

  function automatic void clear_trie();
    nodes_used = 0;
    for (int k = 0; k < DIGITS; k++) child_of[k] = '0;
  endfunction

  // Store the inverse of perm as a path; return 1 when the node store runs out.
  function automatic logic insert_inverse(logic [PERM_W-1:0] perm);
    int len;
    int node;
    int next;
    int slot;
    int v;
    int inv [DIGITS];
    len  = active_len();
    node = 0;
    foreach (inv[i]) inv[i] = 0;
    for (int j = 0; j < len; j++) begin
      v = perm[ELEM_W*j +: ELEM_W];
      if (v < len) inv[v] = j;
    end
    for (int j = 0; j < len; j++) begin
      slot = node * DIGITS + inv[j];
      next = child_of[slot];
      if (next == 0) begin
        if (nodes_used + 1 >= NODES) return 1'b1;
        nodes_used++;
        next = nodes_used;
        for (int k = 0; k < DIGITS; k++) child_of[next*DIGITS + k] = '0;
        child_of[slot] = NODE_W'(next);
      end
      node = next;
    end
    return 1'b0;
  endfunction

  function automatic logic [DEPTH_W-1:0] longest_match(logic [PERM_W-1:0] perm);
    int len;
    int node;
    int next;
    int d;
    int depth;
    len   = active_len();
    node  = 0;
    depth = 0;
    for (int j = 0; j < len; j++) begin
      d = perm[ELEM_W*j +: ELEM_W];
      if (d >= DIGITS) break;
      next = child_of[node*DIGITS + d];
      if (next == 0) break;
      node = next;
      depth++;
    end
    return DEPTH_W'(depth);
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      foreach (child_of[i]) child_of[i] = '0;
      nodes_used  = 0;
      key_length  = KEY_LENGTH_RESET;
      trie_answers_q.delete();
      fail_count  = 0;
      answers_due = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RES_W-1:0]);
        if (trie_answers_q.size() == 0) begin
          $error("result with no operation pending: match_depth %0d, status %0d",
                 got.match_depth, got.status);
          fail_count++;
        end else begin
          want = trie_answers_q.pop_front();
          if (got.match_depth !== want.match_depth) begin
            $error("match_depth: expected %0d, got %0d", want.match_depth, got.match_depth);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (out_tdata[OUT_TDATA_W-1:RES_W] !== '0) begin
            $error("pad: expected 0, got %0h", out_tdata[OUT_TDATA_W-1:RES_W]);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) key_length = cfg_data;
      if (in_tvalid && in_tready) begin
        want = '0;
        case (op_t'(in_tuser))
          OP_CLEAR:  clear_trie();
          OP_INSERT: want.status = insert_inverse(in_tdata);
          OP_QUERY:  want.match_depth = longest_match(in_tdata);
          default:   ;
        endcase
        trie_answers_q.push_back(want);
      end
      answers_due = trie_answers_q.size();
    end
  end

endmodule

### tb/sv/tb_permutation_prefix_trie.sv
`timescale 1ns / 1ps
// Testbench top for the permutation prefix trie: drives operations and key_length
// writes under varying idle patterns and gives the verdict.
// Depends on ppt_pkg, permutation_prefix_trie and ppt_trie_checker.
module tb_permutation_prefix_trie;
  import ppt_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [KEY_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OP_W-1:0]        in_tuser = '0;
  logic [PERM_W-1:0]      in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int answers_due;
  int gap_pct = 0;
  int stall_pct = 0;
  int cur_len = KEY_LENGTH_RESET;
  logic [PERM_W-1:0] stored_keys [$];

  always #2 clk = ~clk;

  permutation_prefix_trie DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ppt_trie_checker trie_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .answers_due (answers_due)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void set_idle(int mode);
    case (mode % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 69; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 69; end
      default: begin gap_pct = 13; stall_pct = 13; end
    endcase
  endfunction

  function automatic logic [PERM_W-1:0] random_bits();
    return PERM_W'({$urandom(), $urandom()});
  endfunction

  // First n elements form a permutation of 0..n-1; the rest stay random.
  function automatic logic [PERM_W-1:0] random_key(int n);
    logic [PERM_W-1:0] key;
    int pool [FIELD_ELEMS];
    int pick;
    int tmp;
    key = random_bits();
    if (n > FIELD_ELEMS) n = FIELD_ELEMS;
    for (int i = 0; i < FIELD_ELEMS; i++) pool[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = pool[i];
      pool[i] = pool[pick];
      pool[pick] = tmp;
    end
    for (int i = 0; i < n; i++) key[ELEM_W*i +: ELEM_W] = ELEM_W'(pool[i]);
    return key;
  endfunction

  function automatic logic [PERM_W-1:0] inverse_key(logic [PERM_W-1:0] key, int n);
    logic [PERM_W-1:0] inv;
    int v;
    inv = random_bits();
    if (n > FIELD_ELEMS) n = FIELD_ELEMS;
    for (int i = 0; i < n; i++) begin
      v = key[ELEM_W*i +: ELEM_W];
      inv[ELEM_W*v +: ELEM_W] = ELEM_W'(i);
    end
    return inv;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_op(op_t op, logic [PERM_W-1:0] perm);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= perm;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every result is back, then write key_length.
  task automatic write_key_length(logic [KEY_W-1:0] value);
    in_tvalid <= 1'b0;
    while (answers_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_len = value;
  endtask

  // Insert a fresh key so that the trie stores the key itself as a path.
  task automatic insert_new_key();
    logic [PERM_W-1:0] key;
    key = random_key(cur_len);
    stored_keys.push_back(key);
    if (stored_keys.size() > 64) void'(stored_keys.pop_front());
    send_op(OP_INSERT, inverse_key(key, cur_len));
  endtask

  task automatic random_op(bit allow_clear);
    logic [PERM_W-1:0] key;
    int roll;
    int pos;
    roll = $urandom_range(99);
    if (roll < 40) begin
      insert_new_key();
    end else if (roll < 48) begin
      send_op(OP_INSERT, random_bits());
    end else if (roll < 70 && stored_keys.size() > 0) begin
      send_op(OP_QUERY, stored_keys[$urandom_range(stored_keys.size() - 1)]);
    end else if (roll < 80 && stored_keys.size() > 0) begin
      key = stored_keys[$urandom_range(stored_keys.size() - 1)];
      pos = $urandom_range(FIELD_ELEMS - 1);
      key[ELEM_W*pos +: ELEM_W] = ELEM_W'($urandom());
      send_op(OP_QUERY, key);
    end else if (roll < 88) begin
      send_op(OP_QUERY, random_key(cur_len));
    end else if (roll < 93) begin
      send_op(OP_QUERY, random_bits());
    end else if (roll < 96) begin
      send_op(OP_NONE, random_bits());
    end else if (allow_clear) begin
      stored_keys.delete();
      send_op(OP_CLEAR, random_bits());
    end else begin
      send_op(OP_QUERY, random_key(cur_len));
    end
  endtask

  initial begin
    logic [KEY_W-1:0] phase_len [10];
    phase_len = '{4, 10, 0, 15, 7, 1, 2, 12, 9, 11};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty trie, identity, digits out of range, malformed inserts
    send_op(OP_QUERY,  40'h00_0000_0000);
    send_op(OP_INSERT, 40'h98_7654_3210);
    send_op(OP_QUERY,  40'h98_7654_3210);
    send_op(OP_QUERY,  40'hFF_FFFF_FF10);
    send_op(OP_QUERY,  40'h98_7654_3211);
    send_op(OP_INSERT, 40'hFF_FFFF_FFFF);
    send_op(OP_INSERT, 40'h33_3333_3333);
    send_op(OP_QUERY,  40'h00_0000_0000);
    send_op(OP_QUERY,  40'h00_0000_9000);
    send_op(OP_NONE,   40'hFF_FFFF_FFFF);
    send_op(OP_INSERT, 40'h01_2345_6789);
    send_op(OP_QUERY,  40'h01_2345_6789);
    send_op(OP_CLEAR,  40'hFF_FFFF_FFFF);
    send_op(OP_QUERY,  40'h98_7654_3210);
    write_key_length(4'd0);
    send_op(OP_INSERT, 40'h98_7654_3210);
    send_op(OP_QUERY,  40'h00_0000_0000);
    write_key_length(4'd15);
    send_op(OP_INSERT, 40'h01_2345_6789);
    send_op(OP_QUERY,  40'h01_2345_6789);
    write_key_length(4'd1);
    send_op(OP_INSERT, 40'h00_0000_0001);
    send_op(OP_QUERY,  40'h00_0000_0005);
    send_op(OP_QUERY,  40'h00_0000_0000);

    // fill the node store until inserts report it full
    write_key_length(4'd10);
    set_idle(1);
    stored_keys.delete();
    send_op(OP_CLEAR, random_bits());
    for (int i = 0; i < 700; i++) begin
      if ($urandom_range(99) < 85) insert_new_key();
      else random_op(1'b0);
    end

    for (int p = 0; p < 10; p++) begin
      write_key_length(phase_len[p]);
      set_idle(p);
      for (int i = 0; i < 100; i++) random_op(1'b1);
    end

    in_tvalid <= 1'b0;
    while (answers_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && answers_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
design/ppt_pkg.sv
design/ppt_front.sv
design/ppt_queue.sv
design/ppt_back.sv
design/permutation_prefix_trie.sv
tb/sv/ppt_trie_checker.sv
tb/sv/tb_permutation_prefix_trie.sv
